@@ rtl/core/dhf_pkg.sv @@
package dhf_pkg;

   // Field widths and frame limits
   localparam int HEIGHT_BITS = 32;
   localparam int THRESH_BITS = 32;
   localparam int MAX_COLS    = 256;
   localparam int MAX_ROWS    = 4096;
   localparam int COL_BITS    = $clog2(MAX_COLS);
   localparam int FCOLS_BITS  = 9;
   localparam int FROWS_BITS  = 13;
   localparam int OUT_ROW_BITS = $clog2(MAX_ROWS);
   localparam int IN_ROW_BITS = FROWS_BITS;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   // Neighbour mean arithmetic
   localparam int NB_COUNT   = 8;
   localparam int CNT_BITS   = 4;
   localparam int PART_BITS  = HEIGHT_BITS + 2;
   localparam int SUM_BITS   = HEIGHT_BITS + 3;
   localparam int DIV_STEPS  = 5;
   localparam int DIV_CHUNK  = (SUM_BITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_BITS   = DIV_CHUNK * DIV_STEPS;
   localparam int STEP_BITS  = $clog2(DIV_STEPS + 1);
   localparam int REM_BITS   = CNT_BITS - 1;

   // Register reset values (threshold is -1e6 m in Q24.8)
   localparam logic [FCOLS_BITS-1:0] FRAME_COLS_RESET = FCOLS_BITS'(129);
   localparam logic [FROWS_BITS-1:0] FRAME_ROWS_RESET = FROWS_BITS'(129);
   localparam logic signed [THRESH_BITS-1:0] THRESH_RESET = -32'sd256000000;
   localparam logic [FCOLS_BITS-1:0] FRAME_COLS_MIN = FCOLS_BITS'(2);
   localparam logic [FCOLS_BITS-1:0] FRAME_COLS_MAX = FCOLS_BITS'(MAX_COLS);
   localparam logic [FROWS_BITS-1:0] FRAME_ROWS_MIN = FROWS_BITS'(2);
   localparam logic [FROWS_BITS-1:0] FRAME_ROWS_MAX = FROWS_BITS'(MAX_ROWS);

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_COLS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_ROWS = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD  = 2'd2;

   // Commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   // Window positions of the eight neighbours (row, column)
   localparam logic [1:0] NB_ROW [NB_COUNT] = '{2'd0, 2'd0, 2'd0, 2'd1,
                                                2'd1, 2'd2, 2'd2, 2'd2};
   localparam logic [1:0] NB_COL [NB_COUNT] = '{2'd0, 2'd1, 2'd2, 2'd0,
                                                2'd2, 2'd0, 2'd1, 2'd2};

   typedef struct packed {
      logic                          command;
      logic signed [HEIGHT_BITS-1:0] height_in;
      logic                          mask_bit;
   } req_payload_type;

   typedef struct packed {
      logic signed [HEIGHT_BITS-1:0] height_out;
      logic                          sample_ok;
      logic                          frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [HEIGHT_BITS-1:0] h;
      logic                          m;
   } cell_type;

   typedef struct packed {
      cell_type row0;
      cell_type row1;
   } line_entry_type;

   typedef struct packed {
      logic                       start;
      logic signed [SUM_BITS-1:0] dividend;
      logic [CNT_BITS-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                          done;
      logic signed [HEIGHT_BITS-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SUM,
      ST_ADD,
      ST_START,
      ST_WAIT,
      ST_DONE
   } state_type;

endpackage

@@ rtl/core/dhf_div.sv @@
module dhf_div (
   input  logic                 clock,
   input  logic                 reset,
   input  dhf_pkg::div_req_type div_req,
   output dhf_pkg::div_rsp_type div_rsp
);

   logic [dhf_pkg::DIV_BITS-1:0]  mag_ff, mag_in;
   logic [dhf_pkg::REM_BITS-1:0]  rem_ff, rem_in;
   logic [dhf_pkg::CNT_BITS-1:0]  div_ff;
   logic                          neg_ff;
   logic                          busy_ff;
   logic [dhf_pkg::STEP_BITS-1:0] step_ff;
   logic                          done_ff;
   logic signed [dhf_pkg::HEIGHT_BITS-1:0] q_ff;
   logic [dhf_pkg::DIV_BITS-1:0]  abs_dividend;

   // Take the magnitude of the dividend at start
   always_comb begin
      if (div_req.dividend[dhf_pkg::SUM_BITS-1]) begin
         abs_dividend = dhf_pkg::DIV_BITS'(-div_req.dividend);
      end else begin
         abs_dividend = dhf_pkg::DIV_BITS'(div_req.dividend);
      end
   end

   // Restoring division, one chunk of quotient bits per cycle
   always_comb begin
      logic [dhf_pkg::CNT_BITS-1:0] trial;
      mag_in = mag_ff;
      rem_in = rem_ff;
      for (int i = 0; i < dhf_pkg::DIV_CHUNK; i++) begin
         trial  = {rem_in, mag_in[dhf_pkg::DIV_BITS-1]};
         mag_in = {mag_in[dhf_pkg::DIV_BITS-2:0], 1'b0};
         if (trial >= div_ff) begin
            rem_in    = dhf_pkg::REM_BITS'(trial - div_ff);
            mag_in[0] = 1'b1;
         end else begin
            rem_in = trial[dhf_pkg::REM_BITS-1:0];
         end
      end
   end

   // Sequence the division and sign the quotient
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == dhf_pkg::STEP_BITS'(dhf_pkg::DIV_STEPS)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         mag_ff <= abs_dividend;
         rem_ff <= '0;
         div_ff <= div_req.divisor;
         neg_ff <= div_req.dividend[dhf_pkg::SUM_BITS-1];
      end else if (busy_ff) begin
         if (step_ff == dhf_pkg::STEP_BITS'(dhf_pkg::DIV_STEPS)) begin
            if (neg_ff) begin
               q_ff <= dhf_pkg::HEIGHT_BITS'(-mag_ff);
            end else begin
               q_ff <= dhf_pkg::HEIGHT_BITS'(mag_ff);
            end
         end else begin
            mag_ff <= mag_in;
            rem_ff <= rem_in;
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q_ff;

endmodule

@@ rtl/core/dem_hole_fill_3x3.sv @@
// Streaming 3x3 hole filler for an elevation raster.
// Request channel (req_valid/req_stall/req_data): one item per pixel in raster
// order, or a flush command that drains one pending result at frame end.
// Result channel (rsp_valid/rsp_stall/rsp_data): one filled height per pixel,
// one row plus one pixel after that pixel's item, frame_end on the last one.
// Register port (csr_valid/csr_ready/csr_index/csr_data): frame width, frame
// height and no-data threshold; write only while no item is in flight.
// One item is handled at a time. Each item reads and writes back its column
// of the two-row line memory in IDLE and LOOK; an item with no result then
// returns to IDLE, a passed or unusable result goes to DONE, and a hole filled
// from its neighbours first passes the adder stages (SUM, ADD) and the serial
// divider (START, WAIT; 5 steps of 7 quotient bits). DONE loads the result.
// The output register lets the next item be taken while a result waits; a
// finished item holds in its last step while rsp_stall keeps the register full.
// Reset clears the raster positions, the window and the output register and
// restores the register defaults; line memory entries are not cleared.
module dem_hole_fill_3x3 (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  dhf_pkg::req_payload_type              req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output dhf_pkg::rsp_payload_type              rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dhf_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [dhf_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   dhf_pkg::state_type state_ff, state_in;

   logic [dhf_pkg::FCOLS_BITS-1:0]   frame_cols_ff;
   logic [dhf_pkg::FROWS_BITS-1:0]   frame_rows_ff;
   logic signed [dhf_pkg::THRESH_BITS-1:0] thresh_ff;

   logic [dhf_pkg::COL_BITS-1:0]     in_col_ff;
   logic [dhf_pkg::IN_ROW_BITS-1:0]  in_row_ff;
   logic [dhf_pkg::COL_BITS-1:0]     out_col_ff;
   logic [dhf_pkg::OUT_ROW_BITS-1:0] out_row_ff;

   dhf_pkg::req_payload_type  item_ff;
   dhf_pkg::line_entry_type   line_mem [dhf_pkg::MAX_COLS];
   dhf_pkg::line_entry_type   rd_ff;
   dhf_pkg::cell_type         win_ff [3][3];
   dhf_pkg::cell_type         we [3][3];
   dhf_pkg::cell_type         newcol [3];
   dhf_pkg::cell_type         px;
   dhf_pkg::cell_type         ctr;

   logic signed [dhf_pkg::HEIGHT_BITS-1:0] nb_h_ff [dhf_pkg::NB_COUNT];
   logic signed [dhf_pkg::HEIGHT_BITS-1:0] nb_h_in [dhf_pkg::NB_COUNT];
   logic [dhf_pkg::CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic signed [dhf_pkg::PART_BITS-1:0] sum_lo_ff, sum_hi_ff;
   logic signed [dhf_pkg::SUM_BITS-1:0]  total_ff;

   logic signed [dhf_pkg::HEIGHT_BITS-1:0] res_h_ff;
   logic res_ok_ff;
   logic res_end_ff;

   logic                      rsp_valid_ff;
   dhf_pkg::rsp_payload_type  rsp_data_ff;

   dhf_pkg::div_req_type div_req;
   dhf_pkg::div_rsp_type div_rsp;

   logic req_accept;
   logic csr_write;
   logic out_load;
   logic look;
   logic emit;
   logic ctr_good;
   logic fill_go;
   logic frame_end;
   logic [2:0] row_ok;
   logic [2:0] col_ok;
   logic [dhf_pkg::FCOLS_BITS-1:0] cols_clamped;
   logic [dhf_pkg::FROWS_BITS-1:0] rows_clamped;
   logic [dhf_pkg::FCOLS_BITS-1:0] in_col_next;
   logic [dhf_pkg::FCOLS_BITS-1:0] out_col_next;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid & csr_ready;
   assign req_accept = req_valid & ~req_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dhf_pkg::ST_IDLE: begin
            if (req_accept) state_in = dhf_pkg::ST_LOOK;
         end
         dhf_pkg::ST_LOOK: begin
            if (!emit) begin
               state_in = dhf_pkg::ST_IDLE;
            end else if (fill_go) begin
               state_in = dhf_pkg::ST_SUM;
            end else begin
               state_in = dhf_pkg::ST_DONE;
            end
         end
         dhf_pkg::ST_SUM:   state_in = dhf_pkg::ST_ADD;
         dhf_pkg::ST_ADD:   state_in = dhf_pkg::ST_START;
         dhf_pkg::ST_START: state_in = dhf_pkg::ST_WAIT;
         dhf_pkg::ST_WAIT: begin
            if (div_rsp.done) state_in = dhf_pkg::ST_DONE;
         end
         dhf_pkg::ST_DONE: begin
            if (out_load) state_in = dhf_pkg::ST_IDLE;
         end
         default: state_in = dhf_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall        = 1'b1;
      look             = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = total_ff;
      div_req.divisor  = cnt_ff;
      out_load         = 1'b0;
      unique case (state_ff)
         dhf_pkg::ST_IDLE:  req_stall = 1'b0;
         dhf_pkg::ST_LOOK:  look = 1'b1;
         dhf_pkg::ST_START: div_req.start = 1'b1;
         dhf_pkg::ST_DONE:  out_load = ~rsp_valid_ff | ~rsp_stall;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= dhf_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // Clamp register writes to the supported frame sizes
   always_comb begin
      cols_clamped = csr_data[dhf_pkg::FCOLS_BITS-1:0];
      if (cols_clamped < dhf_pkg::FRAME_COLS_MIN) cols_clamped = dhf_pkg::FRAME_COLS_MIN;
      if (cols_clamped > dhf_pkg::FRAME_COLS_MAX) cols_clamped = dhf_pkg::FRAME_COLS_MAX;
      rows_clamped = csr_data[dhf_pkg::FROWS_BITS-1:0];
      if (rows_clamped < dhf_pkg::FRAME_ROWS_MIN) rows_clamped = dhf_pkg::FRAME_ROWS_MIN;
      if (rows_clamped > dhf_pkg::FRAME_ROWS_MAX) rows_clamped = dhf_pkg::FRAME_ROWS_MAX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cols_ff <= dhf_pkg::FRAME_COLS_RESET;
         frame_rows_ff <= dhf_pkg::FRAME_ROWS_RESET;
         thresh_ff     <= dhf_pkg::THRESH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            dhf_pkg::CSR_FRAME_COLS: frame_cols_ff <= cols_clamped;
            dhf_pkg::CSR_FRAME_ROWS: frame_rows_ff <= rows_clamped;
            dhf_pkg::CSR_THRESHOLD:  thresh_ff <= dhf_pkg::THRESH_BITS'(csr_data);
            default: ;
         endcase
      end
   end

   // Hold the accepted item and read its column of the line memory
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_data;
         rd_ff   <= line_mem[in_col_ff];
      end
   end

   // Write back the column shifted up by one row
   always_ff @(posedge clock) begin
      if (look) begin
         line_mem[in_col_ff] <= '{row0: rd_ff.row1, row1: px};
      end
   end

   // Build the evaluation window
   always_comb begin
      if (item_ff.command == dhf_pkg::CMD_SAMPLE &&
          in_row_ff < dhf_pkg::IN_ROW_BITS'(frame_rows_ff)) begin
         px.h = item_ff.height_in;
         px.m = item_ff.mask_bit;
      end else begin
         px = '0;
      end
      newcol[0] = rd_ff.row0;
      newcol[1] = rd_ff.row1;
      newcol[2] = px;
      for (int r = 0; r < 3; r++) begin
         we[r][0] = win_ff[r][1];
         we[r][1] = win_ff[r][2];
         we[r][2] = (in_col_ff == '0) ? '0 : newcol[r];
      end
   end

   // Bounds, usable neighbours and the direct result
   always_comb begin
      row_ok[0] = out_row_ff != '0;
      row_ok[1] = 1'b1;
      row_ok[2] = {1'b0, out_row_ff} < frame_rows_ff - 1'b1;
      col_ok[0] = out_col_ff != '0;
      col_ok[1] = 1'b1;
      col_ok[2] = {1'b0, out_col_ff} < frame_cols_ff - 1'b1;
      cnt_in = '0;
      for (int k = 0; k < dhf_pkg::NB_COUNT; k++) begin
         if (row_ok[dhf_pkg::NB_ROW[k]] && col_ok[dhf_pkg::NB_COL[k]] &&
             we[dhf_pkg::NB_ROW[k]][dhf_pkg::NB_COL[k]].m &&
             we[dhf_pkg::NB_ROW[k]][dhf_pkg::NB_COL[k]].h >= thresh_ff) begin
            nb_h_in[k] = we[dhf_pkg::NB_ROW[k]][dhf_pkg::NB_COL[k]].h;
            cnt_in     = cnt_in + 1'b1;
         end else begin
            nb_h_in[k] = '0;
         end
      end
      ctr       = we[1][1];
      ctr_good  = ctr.m && (ctr.h >= thresh_ff);
      emit      = (in_row_ff > dhf_pkg::IN_ROW_BITS'(1)) ||
                  (in_row_ff == dhf_pkg::IN_ROW_BITS'(1) && in_col_ff != '0);
      fill_go   = emit && ctr.m && !ctr_good && (cnt_in != '0);
      frame_end = ({1'b0, out_row_ff} == frame_rows_ff - 1'b1) &&
                  ({1'b0, out_col_ff} == frame_cols_ff - 1'b1);
      in_col_next  = {1'b0, in_col_ff} + 1'b1;
      out_col_next = {1'b0, out_col_ff} + 1'b1;
   end

   // Advance the window
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) win_ff[r][c] <= '0;
         end
      end else if (look) begin
         for (int r = 0; r < 3; r++) begin
            if (in_col_ff == '0) begin
               win_ff[r][0] <= we[r][1];
               win_ff[r][1] <= we[r][2];
               win_ff[r][2] <= newcol[r];
            end else begin
               for (int c = 0; c < 3; c++) win_ff[r][c] <= we[r][c];
            end
         end
      end
   end

   // Advance raster positions; restart on frame end or a size write
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (csr_write && (csr_index == dhf_pkg::CSR_FRAME_COLS ||
                                 csr_index == dhf_pkg::CSR_FRAME_ROWS)) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (look) begin
         if (emit && frame_end) begin
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else begin
            if (emit) begin
               if (out_col_next >= frame_cols_ff) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + 1'b1;
               end else begin
                  out_col_ff <= dhf_pkg::COL_BITS'(out_col_next);
               end
            end
            if (in_col_next >= frame_cols_ff) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + 1'b1;
            end else begin
               in_col_ff <= dhf_pkg::COL_BITS'(in_col_next);
            end
         end
      end
   end

   // Capture neighbours, add them in two stages, collect the result
   always_ff @(posedge clock) begin
      if (look) begin
         nb_h_ff    <= nb_h_in;
         cnt_ff     <= cnt_in;
         res_h_ff   <= ctr_good ? ctr.h : '0;
         res_ok_ff  <= ctr_good;
         res_end_ff <= frame_end;
      end
      if (state_ff == dhf_pkg::ST_SUM) begin
         sum_lo_ff <= dhf_pkg::PART_BITS'(nb_h_ff[0]) + dhf_pkg::PART_BITS'(nb_h_ff[1]) +
                      dhf_pkg::PART_BITS'(nb_h_ff[2]) + dhf_pkg::PART_BITS'(nb_h_ff[3]);
         sum_hi_ff <= dhf_pkg::PART_BITS'(nb_h_ff[4]) + dhf_pkg::PART_BITS'(nb_h_ff[5]) +
                      dhf_pkg::PART_BITS'(nb_h_ff[6]) + dhf_pkg::PART_BITS'(nb_h_ff[7]);
      end
      if (state_ff == dhf_pkg::ST_ADD) begin
         total_ff <= dhf_pkg::SUM_BITS'(sum_lo_ff) + dhf_pkg::SUM_BITS'(sum_hi_ff);
      end
      if (state_ff == dhf_pkg::ST_WAIT && div_rsp.done) begin
         res_h_ff  <= div_rsp.quotient;
         res_ok_ff <= 1'b1;
      end
   end

   dhf_div u_dhf_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Output register: load when empty or being drained, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff.height_out <= res_h_ff;
         rsp_data_ff.sample_ok  <= res_ok_ff;
         rsp_data_ff.frame_end  <= res_end_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/core/dhf_checker.sv @@
module dhf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input dhf_pkg::rsp_payload_type          rsp_data
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // An unusable result carries a zero height
   a_not_ok_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.sample_ok |-> rsp_data.height_out == '0)
      else $error("height not zero on unusable result");

   // Reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One item at a time: a transfer is followed by a stall
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !reset && req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in flight");

endmodule

bind dem_hole_fill_3x3 dhf_checker u_dhf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ dv/dem_hole_fill_3x3_test.sv @@
module dem_hole_fill_3x3_test;
   import dhf_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 20;
   localparam int STAGE_ITEMS   = 120;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_payload_type          req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_payload_type          rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data  = '0;

   dem_hole_fill_3x3 uut (.*);

   // Filler state as the block should hold it
   cell_type                      line_mem [2][MAX_COLS];
   cell_type                      window [3][3];
   logic [FCOLS_BITS-1:0]         frame_cols;
   logic [FROWS_BITS-1:0]         frame_rows;
   logic signed [THRESH_BITS-1:0] thresh;
   logic [FCOLS_BITS-1:0]         in_col;
   logic [FCOLS_BITS-1:0]         out_col;
   logic [FROWS_BITS-1:0]         in_row;
   logic [FROWS_BITS-1:0]         out_row;

   rsp_payload_type expected_fills [$];
   req_payload_type pixel_queue [$];

   int unsent       = 0;
   int items_queued = 0;
   int mismatches   = 0;
   int quiet_cycles = 0;
   int send_gap_pct = 35;
   int stall_pct    = 85;
   int stim_cols;
   int stim_rows;
   logic signed [HEIGHT_BITS-1:0] stim_threshold;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void restart_raster();
      in_col  = '0;
      in_row  = '0;
      out_col = '0;
      out_row = '0;
   endfunction

   function automatic void shift_window(cell_type top, cell_type mid, cell_type bot);
      for (int r = 0; r < 3; r++) begin
         window[r][0] = window[r][1];
         window[r][1] = window[r][2];
      end
      window[0][2] = top;
      window[1][2] = mid;
      window[2][2] = bot;
   endfunction

   // Fill the window centre: pass it, average usable neighbours, or give up
   function automatic rsp_payload_type fill_centre();
      cell_type        centre;
      cell_type        nb;
      longint          total;
      int              count;
      int              y;
      int              x;
      rsp_payload_type fill;
      centre = window[1][1];
      fill   = '0;
      total  = 0;
      count  = 0;
      if (centre.m && centre.h >= thresh) begin
         fill.height_out = centre.h;
         fill.sample_ok  = 1'b1;
      end else if (centre.m) begin
         for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
               nb = window[dr][dc];
               y  = int'(out_row) + dr - 1;
               x  = int'(out_col) + dc - 1;
               if ((dr != 1 || dc != 1) && y >= 0 && y < int'(frame_rows) &&
                   x >= 0 && x < int'(frame_cols) && nb.m && nb.h >= thresh) begin
                  total += nb.h;
                  count++;
               end
            end
         end
         // signed division truncates toward zero
         if (count > 0) begin
            fill.height_out = HEIGHT_BITS'(total / count);
            fill.sample_ok  = 1'b1;
         end
      end
      fill.frame_end = (out_row == frame_rows - 1'b1) && (out_col == frame_cols - 1'b1);
      return fill;
   endfunction

   // Advance the raster by one accepted item and record the fill it releases
   function automatic void absorb_item(req_payload_type item);
      cell_type              px;
      cell_type              top;
      cell_type              mid;
      cell_type              blank;
      logic [FCOLS_BITS-1:0] col;
      logic                  emit;
      rsp_payload_type       fill;
      blank = '0;
      px    = '0;
      fill  = '0;
      col   = in_col;
      emit  = (in_row > 1) || (in_row == 1 && in_col >= 1);
      // flushes and samples past the last row enter as masked-out pixels
      if (item.command == CMD_SAMPLE && in_row < frame_rows) begin
         px.h = item.height_in;
         px.m = item.mask_bit;
      end
      top = line_mem[0][col];
      mid = line_mem[1][col];
      line_mem[0][col] = mid;
      line_mem[1][col] = px;
      // at a new row the pending pixel is on the right edge: void its right column
      if (col == 0) begin
         shift_window(blank, blank, blank);
         if (emit) begin
            fill = fill_centre();
         end
         shift_window(top, mid, px);
      end else begin
         shift_window(top, mid, px);
         if (emit) begin
            fill = fill_centre();
         end
      end
      if (emit) begin
         expected_fills.push_back(fill);
         if (fill.frame_end) begin
            restart_raster();
            return;
         end
         out_col++;
         if (out_col >= frame_cols) begin
            out_col = '0;
            out_row++;
         end
      end
      in_col++;
      if (in_col >= frame_cols) begin
         in_col = '0;
         in_row++;
      end
   endfunction

   // Track every transfer: predict on requests, check results, apply writes
   always @(posedge clock) begin : fill_monitor
      rsp_payload_type       want;
      logic [FCOLS_BITS-1:0] cols_w;
      logic [FROWS_BITS-1:0] rows_w;
      if (reset) begin
         for (int c = 0; c < MAX_COLS; c++) begin
            line_mem[0][c] = '0;
            line_mem[1][c] = '0;
         end
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               window[r][c] = '0;
            end
         end
         restart_raster();
         frame_cols = FRAME_COLS_RESET;
         frame_rows = FRAME_ROWS_RESET;
         thresh     = THRESH_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_fills.size() == 0) begin
               $error("result transfer with no fill pending: height_out %0d ok %0b end %0b",
                      rsp_data.height_out, rsp_data.sample_ok, rsp_data.frame_end);
               mismatches++;
            end else begin
               want = expected_fills.pop_front();
               if (rsp_data.height_out !== want.height_out) begin
                  $error("height_out: expected %0d, got %0d",
                         want.height_out, rsp_data.height_out);
                  mismatches++;
               end
               if (rsp_data.sample_ok !== want.sample_ok) begin
                  $error("sample_ok: expected %0b, got %0b", want.sample_ok, rsp_data.sample_ok);
                  mismatches++;
               end
               if (rsp_data.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_data.frame_end);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            absorb_item(req_data);
            unsent--;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_COLS: begin
                  cols_w = csr_data[FCOLS_BITS-1:0];
                  if (cols_w < FRAME_COLS_MIN) begin
                     cols_w = FRAME_COLS_MIN;
                  end
                  if (cols_w > FRAME_COLS_MAX) begin
                     cols_w = FRAME_COLS_MAX;
                  end
                  frame_cols = cols_w;
                  restart_raster();
               end
               CSR_FRAME_ROWS: begin
                  rows_w = csr_data[FROWS_BITS-1:0];
                  if (rows_w < FRAME_ROWS_MIN) begin
                     rows_w = FRAME_ROWS_MIN;
                  end
                  if (rows_w > FRAME_ROWS_MAX) begin
                     rows_w = FRAME_ROWS_MAX;
                  end
                  frame_rows = rows_w;
                  restart_raster();
               end
               CSR_THRESHOLD: begin
                  thresh = csr_data;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Present queued items, idling at random between transfers
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pixel_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_valid <= 1'b1;
            req_data  <= pixel_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Abort when nothing has been transferred for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_payload_type pixel_item(logic signed [HEIGHT_BITS-1:0] h, logic m);
      req_payload_type item;
      item.command   = CMD_SAMPLE;
      item.height_in = h;
      item.mask_bit  = m;
      return item;
   endfunction

   function automatic req_payload_type flush_item();
      req_payload_type item;
      item.command   = CMD_FLUSH;
      item.height_in = $urandom;
      item.mask_bit  = $urandom_range(1);
      return item;
   endfunction

   // Mostly heights close to the threshold, some saturated, some anywhere
   function automatic req_payload_type random_pixel();
      req_payload_type item;
      int unsigned     pick;
      pick           = $urandom_range(99);
      item.command   = CMD_SAMPLE;
      item.mask_bit  = ($urandom_range(99) < 85);
      if (pick < 4) begin
         item.height_in = 32'sh7FFF_FFFF;
      end else if (pick < 8) begin
         item.height_in = 32'sh8000_0000;
      end else if (pick < 40) begin
         item.height_in = $urandom;
      end else begin
         item.height_in = stim_threshold + HEIGHT_BITS'(int'($urandom_range(8191)) - 4096);
      end
      return item;
   endfunction

   function automatic void queue_item(req_payload_type item);
      pixel_queue.push_back(item);
      unsent++;
      items_queued++;
   endfunction

   task automatic write_register(logic [CSR_IDX_BITS-1:0] idx,
                                 logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Hold until every item is taken and every fill has come out, then settle
   task automatic wait_drained();
      do @(posedge clock); while (unsent != 0 || expected_fills.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int stage_start;
      int drain;
      bit pause_due;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 2x2 frames from clamped sizes: saturated heights and two holes
      write_register(CSR_FRAME_COLS, 32'd0);
      write_register(CSR_FRAME_ROWS, 32'd1);
      write_register(CSR_THRESHOLD, 32'd0);
      stim_threshold = 0;
      queue_item(pixel_item(32'sh7FFF_FFFF, 1'b1));
      queue_item(pixel_item(32'sh7FFF_FFFE, 1'b1));
      queue_item(pixel_item(-32'sd1, 1'b1));
      queue_item(pixel_item(32'sh8000_0000, 1'b1));
      repeat (3) queue_item(flush_item());
      wait_drained();

      // negative mean truncating toward zero, flush in place of the last pixel,
      // a sample arriving during the drain
      write_register(CSR_THRESHOLD, -32'sd100);
      stim_threshold = -100;
      queue_item(pixel_item(-32'sd7, 1'b1));
      queue_item(pixel_item(-32'sd2, 1'b1));
      queue_item(pixel_item(-32'sd1000, 1'b1));
      queue_item(flush_item());
      queue_item(flush_item());
      queue_item(random_pixel());
      queue_item(flush_item());

      // holes with no usable neighbour and masked-out pixels
      queue_item(pixel_item(-32'sd1, 1'b0));
      queue_item(pixel_item(-32'sd500, 1'b1));
      queue_item(pixel_item(-32'sd600, 1'b1));
      queue_item(pixel_item(32'sd50, 1'b0));
      repeat (3) queue_item(flush_item());
      wait_drained();
      write_register(CSR_SPARE, $urandom);

      // widest and tallest frame at once, clamped from above, run part way
      write_register(CSR_FRAME_COLS, 32'h0000_01FF);
      write_register(CSR_FRAME_ROWS, 32'hFFFF_FFFF);
      write_register(CSR_THRESHOLD, THRESH_RESET);
      stim_threshold = THRESH_RESET;
      repeat (270) queue_item(random_pixel());
      wait_drained();
      write_register(CSR_FRAME_COLS, 32'd3);
      write_register(CSR_FRAME_ROWS, 32'h0000_1000);
      write_register(CSR_THRESHOLD, 32'h8000_0000);
      stim_threshold = 32'sh8000_0000;
      repeat (20) queue_item(random_pixel());
      wait_drained();
      write_register(CSR_THRESHOLD, 32'h7FFF_FFFF);
      stim_threshold = 32'sh7FFF_FFFF;
      repeat (20) queue_item(random_pixel());

      // random small frames under three idling patterns
      for (int stage = 0; stage < 3; stage++) begin
         send_gap_pct = (stage == 0) ? 35 : (stage == 1) ? 85 : 0;
         stall_pct    = (stage == 0) ? 85 : (stage == 1) ? 35 : 0;
         stage_start  = items_queued;
         pause_due    = 1'b1;
         while (items_queued - stage_start < STAGE_ITEMS) begin
            wait_drained();
            // now and then keep the geometry and the raster position
            if ($urandom_range(3) != 0) begin
               stim_cols = $urandom_range(2, 9);
               stim_rows = $urandom_range(2, 6);
               write_register(CSR_FRAME_COLS, ($urandom & ~32'h1FF) | 32'(stim_cols));
               write_register(CSR_FRAME_ROWS, ($urandom & ~32'h1FFF) | 32'(stim_rows));
            end
            case ($urandom_range(5))
               0: stim_threshold = THRESH_RESET;
               1: stim_threshold = 0;
               2: stim_threshold = 32'sh8000_0000;
               3: stim_threshold = 32'sh7FFF_FFFF;
               4: stim_threshold = $urandom;
               default: stim_threshold = int'($urandom_range(2000)) - 1000;
            endcase
            write_register(CSR_THRESHOLD, stim_threshold);
            repeat ($urandom_range(1, 3)) begin
               for (int i = 0; i < stim_cols * stim_rows; i++) begin
                  // once per stage, hold the sender mid frame until all fills are out
                  if (pause_due && i == stim_cols * stim_rows / 2) begin
                     wait_drained();
                     pause_due = 1'b0;
                  end
                  queue_item(($urandom_range(99) < 3) ? flush_item() : random_pixel());
               end
               // usually an exact drain, sometimes too short or too long
               drain = stim_cols + 1;
               if ($urandom_range(9) == 0) begin
                  drain = stim_cols - 2 + int'($urandom_range(6));
               end
               repeat (drain) begin
                  queue_item(($urandom_range(99) < 75) ? flush_item() : random_pixel());
               end
            end
         end
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
